>>> rtl/dlqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock queue manager package
// Shared types and constants for the lock queue manager front, queue and back.
// ----------------------------------------------------------------------------
package dlqm_pkg;

    // Field widths and the ranges that the input fields can express.
    localparam int TXN_W     = 8;
    localparam int BKT_W     = 10;
    localparam int CNT_W     = 8;
    localparam int TXN_RANGE = 256;
    localparam int BKT_RANGE = 1024;

    // Command queue between the front and the back.
    localparam int CMDQ_DEPTH = 4;

    // Release items report at most this many ready transactions.
    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic {
        OP_LOCK    = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    // Classified command as it travels from the front to the back.
    typedef struct packed {
        op_t              kind;
        logic [TXN_W-1:0] txn;
        logic [BKT_W-1:0] bucket;
        logic             wr;
        logic             closes;
    } cmd_t;

    // One lock request held in a bucket queue.
    typedef struct packed {
        logic             wr;
        logic [TXN_W-1:0] txn;
    } entry_t;

    // One result item.
    typedef struct packed {
        logic [TXN_W-1:0] txn;
        logic             is_ready;
        logic [CNT_W-1:0] blocked;
        logic             ovf;
        logic             last;
    } result_t;

endpackage

>>> rtl/dlqm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock queue manager front
// Accepts input items, reduces transaction and bucket into range and hands
// the classified command to the command queue.
// ----------------------------------------------------------------------------
module dlqm_front
    import dlqm_pkg::*;
#(
    parameter int BUCKETS   = 1024,
    parameter int TXN_SLOTS = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             kind,
    input  logic [TXN_W-1:0] txn_id,
    input  logic [BKT_W-1:0] bucket,
    input  logic             write_mode,
    input  logic             closes_txn,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output cmd_t             cmd
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_REDUCE,
        F_PUSH
    } fstate_t;

    // Reciprocal constants: the quotient is (x * RCP) >> SH, exact for
    // every field value below the field range.
    localparam int          BKT_SH     = 2 * BKT_W;
    localparam int          TXN_SH     = 2 * TXN_W;
    localparam logic [31:0] BKT_MOD    = 32'(BUCKETS);
    localparam logic [31:0] TXN_MOD    = 32'(TXN_SLOTS);
    localparam logic [31:0] BKT_RCP    = 32'(((1 << BKT_SH) + BUCKETS - 1) / BUCKETS);
    localparam logic [31:0] TXN_RCP    = 32'(((1 << TXN_SH) + TXN_SLOTS - 1) / TXN_SLOTS);
    localparam bit          BKT_REDUCE = (BUCKETS < BKT_RANGE);
    localparam bit          TXN_REDUCE = (TXN_SLOTS < TXN_RANGE);

    fstate_t          state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [31:0]      bkt_prod;
    logic [31:0]      bkt_back;
    logic [BKT_W-1:0] bkt_rem;
    logic [31:0]      txn_prod;
    logic [31:0]      txn_back;
    logic [TXN_W-1:0] txn_rem;

    // Remainder by reciprocal multiplication and one subtraction.
    assign bkt_prod = {{(32 - BKT_W){1'b0}}, cmd_reg.bucket} * BKT_RCP;
    assign bkt_back = (bkt_prod >> BKT_SH) * BKT_MOD;
    assign bkt_rem  = cmd_reg.bucket - bkt_back[BKT_W-1:0];
    assign txn_prod = {{(32 - TXN_W){1'b0}}, cmd_reg.txn} * TXN_RCP;
    assign txn_back = (txn_prod >> TXN_SH) * TXN_MOD;
    assign txn_rem  = cmd_reg.txn - txn_back[TXN_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next.kind   = op_t'(kind);
                    cmd_next.txn    = txn_id;
                    cmd_next.bucket = bucket;
                    cmd_next.wr     = write_mode;
                    cmd_next.closes = closes_txn;
                    state_next      = F_REDUCE;
                end
            end
            F_REDUCE:
            begin
                if (BKT_REDUCE)
                begin
                    cmd_next.bucket = bkt_rem;
                end
                if (TXN_REDUCE)
                begin
                    cmd_next.txn = txn_rem;
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (cmd_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // State and registered command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign in_ready  = (state_reg == F_IDLE);
    assign cmd_valid = (state_reg == F_PUSH);
    assign cmd       = cmd_reg;

endmodule

>>> rtl/dlqm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock queue manager command queue
// Short first-in first-out queue of classified commands between the front
// and the back.
// ----------------------------------------------------------------------------
module dlqm_fifo
    import dlqm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int QW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    cmd_t          slot_reg [CMDQ_DEPTH];
    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(CMDQ_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + QW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + QW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/dlqm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock queue manager back
// Holds the bucket queues and wait counts, carries out lock and release
// commands and drives the result register.
// ----------------------------------------------------------------------------
module dlqm_back
    import dlqm_pkg::*;
#(
    parameter int BUCKETS     = 1024,
    parameter int QUEUE_DEPTH = 8,
    parameter int TXN_SLOTS   = 256
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int BK_DEPTH  = (BUCKETS < BKT_RANGE) ? BUCKETS : BKT_RANGE;
    localparam int WC_DEPTH  = (TXN_SLOTS < TXN_RANGE) ? TXN_SLOTS : TXN_RANGE;
    localparam int CLR_DEPTH = (BK_DEPTH > WC_DEPTH) ? BK_DEPTH : WC_DEPTH;
    localparam int BW        = $clog2(BK_DEPTH);
    localparam int WCW       = $clog2(WC_DEPTH);
    localparam int CLW       = $clog2(CLR_DEPTH);
    localparam int PW        = $clog2(QUEUE_DEPTH);
    localparam int FW        = $clog2(QUEUE_DEPTH + 1);

    typedef entry_t [QUEUE_DEPTH-1:0] row_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOCK,
        S_SCAN,
        S_DECIDE,
        S_GRANT,
        S_WCUPD,
        S_REMOVE
    } bstate_t;

    // Memories: one row of requests and one fill count per bucket,
    // one wait count per transaction slot.
    row_t             row_mem  [BK_DEPTH];
    logic [FW-1:0]    fill_mem [BK_DEPTH];
    logic [CNT_W-1:0] wc_mem   [WC_DEPTH];

    row_t             row_rd;
    logic [FW-1:0]    fill_rd;
    logic [CNT_W-1:0] wc_rd;

    bstate_t              state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [CLW-1:0]       clr_reg, clr_next;
    logic [FW-1:0]        ptr_reg, ptr_next;
    logic [PW-1:0]        p_reg, p_next;
    logic                 p_wr_reg, p_wr_next;
    logic                 wr_before_reg, wr_before_next;
    logic                 single_reg, single_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [TXN_W-1:0]     pend_txn_reg, pend_txn_next;
    logic [CNT_W-1:0]     rb_reg, rb_next;
    logic                 sticky_reg, sticky_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              res_reg, res_next;

    logic             row_re;
    logic [BW-1:0]    rd_bkt;
    logic             row_we;
    row_t             row_wdata;
    logic             fill_we;
    logic [BW-1:0]    fill_waddr;
    logic [FW-1:0]    fill_wdata;
    logic             wc_re;
    logic [WCW-1:0]   wc_raddr;
    logic             wc_we;
    logic [WCW-1:0]   wc_waddr;
    logic [CNT_W-1:0] wc_wdata;
    logic             push;
    result_t          push_data;
    logic             push_ok;

    entry_t           e_ptr;
    logic [FW-1:0]    nx;
    logic             tail_same;
    logic             full;
    logic             any_wr;
    logic             append;
    logic             blocked;
    logic [CNT_W-1:0] rb_new;
    logic             ovf_new;
    row_t             row_app;
    row_t             row_rem;
    logic             cond_head;
    logic             cond_lone_wr;
    logic             report;

    assign push_ok = !out_valid_reg || res_ready;
    assign e_ptr   = row_rd[ptr_reg[PW-1:0]];
    assign nx      = FW'(p_reg) + FW'(1);

    // Lock classification on the row just read.
    always_comb
    begin
        any_wr  = 1'b0;
        row_app = row_rd;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if ((FW'(i) < fill_rd) && row_rd[i].wr)
            begin
                any_wr = 1'b1;
            end
            if (FW'(i) == fill_rd)
            begin
                row_app[i].wr  = cmd_reg.wr;
                row_app[i].txn = cmd_reg.txn;
            end
        end
    end

    assign tail_same = (fill_rd != '0) &&
                       (row_rd[PW'(fill_rd - FW'(1))].txn == cmd_reg.txn);
    assign full      = (fill_rd >= FW'(QUEUE_DEPTH));
    assign append    = !tail_same && !full;
    assign blocked   = append && (cmd_reg.wr ? (fill_rd != '0) : any_wr);
    assign rb_new    = (blocked && (rb_reg != CNT_MAX)) ? rb_reg + CNT_W'(1) : rb_reg;
    assign ovf_new   = sticky_reg || (!tail_same && full);

    // Removal closes the gap left by the released request.
    always_comb
    begin
        row_rem = row_rd;
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            if (PW'(i) >= p_reg)
            begin
                row_rem[i] = row_rd[i + 1];
            end
        end
    end

    // Grant rules, checked on the request after the released one.
    assign cond_head    = (p_reg == '0) && (p_wr_reg || e_ptr.wr);
    assign cond_lone_wr = !wr_before_reg && p_wr_reg && !e_ptr.wr;
    assign report       = (wc_rd == CNT_W'(1)) && (n_reg < RES_CNT_W'(MAX_RESULTS));

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        clr_next        = clr_reg;
        ptr_next        = ptr_reg;
        p_next          = p_reg;
        p_wr_next       = p_wr_reg;
        wr_before_next  = wr_before_reg;
        single_next     = single_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_txn_next   = pend_txn_reg;
        rb_next         = rb_reg;
        sticky_next     = sticky_reg;
        row_re          = 1'b0;
        rd_bkt          = cmd.bucket[BW-1:0];
        row_we          = 1'b0;
        row_wdata       = row_app;
        fill_we         = 1'b0;
        fill_waddr      = cmd_reg.bucket[BW-1:0];
        fill_wdata      = fill_rd + FW'(1);
        wc_re           = 1'b0;
        wc_raddr        = e_ptr.txn[WCW-1:0];
        wc_we           = 1'b0;
        wc_waddr        = cmd_reg.txn[WCW-1:0];
        wc_wdata        = rb_new;
        push            = 1'b0;
        push_data       = '0;
        cmd_ready       = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                fill_waddr = clr_reg[BW-1:0];
                fill_wdata = '0;
                fill_we    = ({1'b0, clr_reg} < (CLW + 1)'(BK_DEPTH));
                wc_waddr   = clr_reg[WCW-1:0];
                wc_wdata   = '0;
                wc_we      = ({1'b0, clr_reg} < (CLW + 1)'(WC_DEPTH));
                if (clr_reg == CLW'(CLR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + CLW'(1);
                end
            end
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    row_re          = 1'b1;
                    cmd_next        = cmd;
                    ptr_next        = '0;
                    wr_before_next  = 1'b0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    state_next      = (cmd.kind == OP_LOCK) ? S_LOCK : S_SCAN;
                end
            end
            S_LOCK:
            begin
                if (!cmd_reg.closes || push_ok)
                begin
                    row_we  = append;
                    fill_we = append;
                    if (cmd_reg.closes)
                    begin
                        push               = 1'b1;
                        push_data.txn      = cmd_reg.txn;
                        push_data.is_ready = (rb_new == '0);
                        push_data.blocked  = rb_new;
                        push_data.ovf      = ovf_new;
                        push_data.last     = 1'b1;
                        wc_we              = 1'b1;
                        rb_next            = '0;
                        sticky_next        = 1'b0;
                    end
                    else
                    begin
                        rb_next     = rb_new;
                        sticky_next = ovf_new;
                    end
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (ptr_reg >= fill_rd)
                begin
                    state_next = S_IDLE;
                end
                else if (e_ptr.txn == cmd_reg.txn)
                begin
                    p_next     = ptr_reg[PW-1:0];
                    p_wr_next  = e_ptr.wr;
                    ptr_next   = ptr_reg + FW'(1);
                    state_next = S_DECIDE;
                end
                else
                begin
                    wr_before_next = wr_before_reg || e_ptr.wr;
                    ptr_next       = ptr_reg + FW'(1);
                end
            end
            S_DECIDE:
            begin
                if (ptr_reg >= fill_rd)
                begin
                    state_next = S_REMOVE;
                end
                else if (cond_head && e_ptr.wr)
                begin
                    single_next = 1'b1;
                    state_next  = S_GRANT;
                end
                else if (cond_head || cond_lone_wr)
                begin
                    single_next = 1'b0;
                    state_next  = S_GRANT;
                end
                else
                begin
                    state_next = S_REMOVE;
                end
            end
            S_GRANT:
            begin
                if ((ptr_reg >= fill_rd) || (single_reg ? (ptr_reg != nx) : e_ptr.wr))
                begin
                    state_next = S_REMOVE;
                end
                else
                begin
                    wc_re      = 1'b1;
                    state_next = S_WCUPD;
                end
            end
            S_WCUPD:
            begin
                wc_waddr = e_ptr.txn[WCW-1:0];
                wc_wdata = wc_rd - CNT_W'(1);
                if (wc_rd == '0)
                begin
                    ptr_next   = ptr_reg + FW'(1);
                    state_next = S_GRANT;
                end
                else if (!(report && pend_valid_reg) || push_ok)
                begin
                    wc_we = 1'b1;
                    if (report)
                    begin
                        if (pend_valid_reg)
                        begin
                            push               = 1'b1;
                            push_data.txn      = pend_txn_reg;
                            push_data.is_ready = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_txn_next   = e_ptr.txn;
                        n_next          = n_reg + RES_CNT_W'(1);
                    end
                    ptr_next   = ptr_reg + FW'(1);
                    state_next = S_GRANT;
                end
            end
            S_REMOVE:
            begin
                if (!pend_valid_reg || push_ok)
                begin
                    row_we     = 1'b1;
                    row_wdata  = row_rem;
                    fill_we    = 1'b1;
                    fill_wdata = fill_rd - FW'(1);
                    if (pend_valid_reg)
                    begin
                        push               = 1'b1;
                        push_data.txn      = pend_txn_reg;
                        push_data.is_ready = 1'b1;
                        push_data.last     = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            res_next       = push_data;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State, control and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            ptr_reg        <= '0;
            p_reg          <= '0;
            p_wr_reg       <= 1'b0;
            wr_before_reg  <= 1'b0;
            single_reg     <= 1'b0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            rb_reg         <= '0;
            sticky_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            ptr_reg        <= ptr_next;
            p_reg          <= p_next;
            p_wr_reg       <= p_wr_next;
            wr_before_reg  <= wr_before_next;
            single_reg     <= single_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            rb_reg         <= rb_next;
            sticky_reg     <= sticky_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pend_txn_reg <= pend_txn_next;
        res_reg      <= res_next;
    end

    // Request rows and fill counts, read together by bucket.
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[cmd_reg.bucket[BW-1:0]] <= row_wdata;
        end
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (row_re)
        begin
            row_rd  <= row_mem[rd_bkt];
            fill_rd <= fill_mem[rd_bkt];
        end
    end

    // Wait counts.
    always_ff @(posedge clk)
    begin
        if (wc_we)
        begin
            wc_mem[wc_waddr] <= wc_wdata;
        end
        if (wc_re)
        begin
            wc_rd <= wc_mem[wc_raddr];
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

>>> rtl/deterministic_lock_queue_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deterministic lock queue manager
// Lock table with one request queue per bucket and a wait count per
// transaction; reports transactions that hold all their locks.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid / in_ready  kind, txn_id, bucket, write_mode,
//                                            closes_txn
//  output    out        out_valid/out_ready  ready_txn, is_ready, blocked_locks,
//                                            overflow, last
//
//  The front takes one item at a time: accept, range reduction of bucket and
//  transaction by reciprocal multiplication, and the hand-off to the queue.
//  For a lock item the back reads the bucket's row and appends unless the
//  tail is the same transaction or the row is full. A release item scans the
//  row for its request, decides on grants, updates the wait count of each
//  request in the granted range and removes the request; one that finds
//  nothing ends after the scan. After reset the back clears fill and wait
//  counts, one entry a cycle, up to the larger of the bucket and slot counts.
//  Either side may stall; the command queue and result register decouple them.
// ----------------------------------------------------------------------------
module deterministic_lock_queue_manager
    import dlqm_pkg::*;
#(
    parameter int BUCKETS     = 1024,
    parameter int QUEUE_DEPTH = 8,
    parameter int TXN_SLOTS   = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             kind,
    input  logic [TXN_W-1:0] txn_id,
    input  logic [BKT_W-1:0] bucket,
    input  logic             write_mode,
    input  logic             closes_txn,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [TXN_W-1:0] ready_txn,
    output logic             is_ready,
    output logic [CNT_W-1:0] blocked_locks,
    output logic             overflow,
    output logic             last
);

    logic    fq_valid;
    logic    fq_ready;
    cmd_t    fq_cmd;
    logic    qb_valid;
    logic    qb_ready;
    cmd_t    qb_cmd;
    result_t res;

    // Front: accept and reduce.
    dlqm_front #(
        .BUCKETS   (BUCKETS),
        .TXN_SLOTS (TXN_SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .txn_id     (txn_id),
        .bucket     (bucket),
        .write_mode (write_mode),
        .closes_txn (closes_txn),
        .cmd_valid  (fq_valid),
        .cmd_ready  (fq_ready),
        .cmd        (fq_cmd)
    );

    // Command queue.
    dlqm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_cmd)
    );

    // Back: lock table engine.
    dlqm_back #(
        .BUCKETS     (BUCKETS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TXN_SLOTS   (TXN_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign ready_txn     = res.txn;
    assign is_ready      = res.is_ready;
    assign blocked_locks = res.blocked;
    assign overflow      = res.ovf;
    assign last          = res.last;

`ifndef NO_ASSERTIONS
    // A result that reports blocked locks closes a lock item and is not ready.
    a_blocked_is_lock: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (blocked_locks != '0) |-> !is_ready && last)
        else $error("blocked result not marked as closing lock result");

    // Results that are not the last of their item come from releases only.
    a_release_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> is_ready && (blocked_locks == '0) && !overflow)
        else $error("intermediate result has lock fields set");

    // A command offered to a full queue is held by the front until the queue takes it.
    a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fq_valid && !fq_ready |=> fq_valid)
        else $error("front dropped a command while the queue was full");
`endif

endmodule

>>> verif/deterministic_lock_queue_manager_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock queue manager testbench
// Drives lock and release transfers into the lock table, predicts the ready
// and blocked reports from its own copy of the bucket queues and wait counts,
// and checks every result transfer in order under random stalls on both sides.
// ----------------------------------------------------------------------------
module deterministic_lock_queue_manager_test;
    import dlqm_pkg::*;

    localparam int DEPTH       = 8;
    localparam int IDLE_LIMIT  = 6000;
    localparam int SAT_BASE    = 100;
    localparam int SAT_BUCKETS = 37;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic             kind = 1'b0;
    logic [TXN_W-1:0] txn_id = '0;
    logic [BKT_W-1:0] bucket = '0;
    logic             write_mode = 1'b0;
    logic             closes_txn = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [TXN_W-1:0] ready_txn;
    logic             is_ready;
    logic [CNT_W-1:0] blocked_locks;
    logic             overflow;
    logic             last;

    // Predicted lock table.
    entry_t           lock_queue [BKT_RANGE][DEPTH];
    int               queue_fill [BKT_RANGE];
    logic [CNT_W-1:0] wait_cnt [TXN_RANGE];
    logic [CNT_W-1:0] open_tally = '0;
    logic             open_overflow = 1'b0;
    result_t          pending_reports [$];

    // Buckets each active transaction holds, for building releases.
    int  held_buckets [TXN_RANGE][$];
    bit  txn_active [TXN_RANGE];
    int  active_list [$];

    int  errors = 0;
    int  send_idle = 0;
    int  recv_idle = 0;
    int  hold_len = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  quiet_cycles = 0;

    deterministic_lock_queue_manager DUT (.*);

    initial begin
        forever #5 clk = ~clk;
    end

    // Append one predicted report at the tail of the expected list.
    function automatic void queue_report(result_t r);
        pending_reports = {pending_reports, r};
    endfunction

    // Lock transfer: append unless the tail is ours, tally blocked requests.
    function automatic void predict_lock(int t, int b, bit wr, bit closes);
        int  n;
        bit  blk;
        result_t r;
        n = queue_fill[b];
        blk = 1'b0;
        if (!(n > 0 && lock_queue[b][n-1].txn == t)) begin
            if (n >= DEPTH) begin
                open_overflow = 1'b1;
            end
            else begin
                lock_queue[b][n].txn = TXN_W'(t);
                lock_queue[b][n].wr = wr;
                if (wr) begin
                    blk = (n > 0);
                end
                else begin
                    for (int i = 0; i < n; i++)
                        if (lock_queue[b][i].wr) blk = 1'b1;
                end
                queue_fill[b] = n + 1;
                if (blk && open_tally != CNT_MAX) open_tally++;
            end
        end
        if (closes) begin
            r.txn = TXN_W'(t);
            r.is_ready = (open_tally == 0);
            r.blocked = open_tally;
            r.ovf = open_overflow;
            r.last = 1'b1;
            queue_report(r);
            wait_cnt[t] = open_tally;
            open_tally = '0;
            open_overflow = 1'b0;
        end
    endfunction

    // Release transfer: remove the request, grant followers, report ready ones.
    function automatic void predict_release(int t, int b);
        int  n, p, start, stop, nx, cnt, g;
        bit  wr_seen;
        result_t r;
        n = queue_fill[b];
        start = 0;
        stop = 0;
        cnt = 0;
        wr_seen = 1'b0;
        for (p = 0; p < n && lock_queue[b][p].txn != t; p++)
            if (lock_queue[b][p].wr) wr_seen = 1'b1;
        if (p >= n) return;
        if (p + 1 < n) begin
            nx = p + 1;
            if (p == 0 && (lock_queue[b][p].wr || lock_queue[b][nx].wr)) begin
                start = nx;
                if (lock_queue[b][nx].wr) stop = nx + 1;
                else
                    for (stop = nx; stop < n && !lock_queue[b][stop].wr; stop++) ;
            end
            else if (!wr_seen && lock_queue[b][p].wr && !lock_queue[b][nx].wr) begin
                start = nx;
                for (stop = nx; stop < n && !lock_queue[b][stop].wr; stop++) ;
            end
            for (int i = start; i < stop; i++) begin
                g = lock_queue[b][i].txn;
                if (wait_cnt[g] > 0) begin
                    wait_cnt[g]--;
                    if (wait_cnt[g] == 0 && cnt < MAX_RESULTS) begin
                        r.txn = TXN_W'(g);
                        r.is_ready = 1'b1;
                        r.blocked = '0;
                        r.ovf = 1'b0;
                        r.last = 1'b0;
                        queue_report(r);
                        cnt++;
                    end
                end
            end
        end
        for (int i = p; i + 1 < n; i++)
            lock_queue[b][i] = lock_queue[b][i+1];
        queue_fill[b] = n - 1;
        if (cnt > 0) pending_reports[pending_reports.size()-1].last = 1'b1;
    endfunction

    // Offer one item and hold it until the transfer happens.
    task automatic send_item(op_t op, int t, int b, bit wr, bit closes);
        if ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        kind <= op;
        txn_id <= TXN_W'(t);
        bucket <= BKT_W'(b);
        write_mode <= wr;
        closes_txn <= closes;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (op == OP_LOCK) predict_lock(t, b, wr, closes);
        else predict_release(t, b);
    endtask

    task automatic lock_item(int t, int b, bit wr, bit closes);
        send_item(OP_LOCK, t, b, wr, closes);
    endtask

    task automatic release_item(int t, int b);
        send_item(OP_RELEASE, t, b, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // Wait until all reports are in, then let the back settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Receiver side: random stalls, or one long hold-off once requested.
    always @(posedge clk) begin
        if (!hold_done && hold_len > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_len - 1;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Compare each result transfer with the oldest predicted report.
    always @(posedge clk) begin
        result_t exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result txn=%0d ready=%0d blocked=%0d ovf=%0d last=%0d",
                         $time, ready_txn, is_ready, blocked_locks, overflow, last);
                errors++;
            end
            else begin
                exp_r = pending_reports.pop_front();
                if (exp_r.txn != ready_txn || exp_r.is_ready != is_ready ||
                    exp_r.blocked != blocked_locks || exp_r.ovf != overflow ||
                    exp_r.last != last) begin
                    $display("%0t: expected txn=%0d ready=%0d blocked=%0d ovf=%0d last=%0d",
                             $time, exp_r.txn, exp_r.is_ready, exp_r.blocked,
                             exp_r.ovf, exp_r.last);
                    $display("%0t: actual   txn=%0d ready=%0d blocked=%0d ovf=%0d last=%0d",
                             $time, ready_txn, is_ready, blocked_locks, overflow, last);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Field extremes, grants of writes and read runs, tail skip, full bucket.
    task automatic test_directed();
        lock_item(255, 1023, 1'b1, 1'b1);
        lock_item(0, 1023, 1'b0, 1'b0);
        lock_item(0, 1023, 1'b0, 1'b0);
        lock_item(0, 0, 1'b0, 1'b1);
        lock_item(7, 1023, 1'b0, 1'b1);
        lock_item(9, 1023, 1'b1, 1'b1);
        release_item(255, 1023);
        release_item(0, 1023);
        release_item(7, 1023);
        release_item(9, 1023);
        release_item(42, 0);
        release_item(0, 0);
        for (int i = 0; i < DEPTH; i++)
            lock_item(20 + i, 1, i == 0, 1'b1);
        lock_item(30, 1, 1'b0, 1'b1);
        release_item(20, 1);
        release_item(21, 1);
        drain();
    endtask

    // Tally saturation: two transactions alternate writes into each bucket,
    // so every append after the first one in a bucket is blocked.
    task automatic test_tally_saturation();
        for (int b = 0; b < SAT_BUCKETS; b++)
            for (int j = 0; j < DEPTH; j++)
                lock_item(200 + (j % 2), SAT_BASE + b, 1'b1,
                          (b == SAT_BUCKETS - 1) && (j == DEPTH - 1));
        drain();
    endtask

    // Random transactions: lock groups, full releases, and stray releases.
    task automatic run_random(int items);
        int sent, t, k, b, idx;
        sent = 0;
        while (sent < items) begin
            if (active_list.size() < 12 && $urandom_range(99) < 55) begin
                do t = $urandom_range(255); while (txn_active[t] || t == 200 || t == 201);
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++) begin
                    if ($urandom_range(9) == 0) b = $urandom_range(400, 1023);
                    else b = $urandom_range(15);
                    held_buckets[t] = {held_buckets[t], b};
                    lock_item(t, b, 1'($urandom_range(1)), i == k - 1);
                end
                txn_active[t] = 1'b1;
                active_list = {active_list, t};
                sent += k;
            end
            else if (active_list.size() > 0 && $urandom_range(9) != 0) begin
                idx = $urandom_range(active_list.size() - 1);
                t = active_list[idx];
                active_list.delete(idx);
                held_buckets[t].shuffle();
                while (held_buckets[t].size() > 0) begin
                    release_item(t, held_buckets[t].pop_front());
                    sent++;
                end
                txn_active[t] = 1'b0;
            end
            else begin
                release_item($urandom_range(255), $urandom_range(15));
                sent++;
            end
        end
    endtask

    initial begin
        foreach (queue_fill[i]) queue_fill[i] = 0;
        foreach (wait_cnt[i]) wait_cnt[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_idle = 9;
        recv_idle = 45;
        test_directed();
        test_tally_saturation();
        hold_len = 400;
        run_random(20);
        drain();

        send_idle = 45;
        recv_idle = 9;
        run_random(20);
        drain();

        send_idle = 0;
        recv_idle = 0;
        run_random(20);
        drain();

        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
rtl/dlqm_pkg.sv
rtl/dlqm_front.sv
rtl/dlqm_fifo.sv
rtl/dlqm_back.sv
rtl/deterministic_lock_queue_manager.sv
verif/deterministic_lock_queue_manager_test.sv
